// ----- hw/rtl/aria_pkg.sv -----
// ----------------------------------------------------------------------------
// ARIA package
// S-boxes, diffusion layer and key schedule constants shared by the cipher.
// ----------------------------------------------------------------------------
package aria_pkg;

	localparam int unsigned BLK_W = 128;
	localparam int unsigned HALF_W = 64;
	localparam int unsigned CFG_IDX_W = 2;

	typedef logic [BLK_W-1:0] blk_t;
	typedef logic [7:0] byte_t;

	// key constants CK1..CK3
	localparam logic [HALF_W-1:0] CK_WORDS [6] = '{
		64'h517cc1b727220a94, 64'hfe13abe8fa9a6ee0,
		64'h6db14acc9e21c820, 64'hff28b1d5ef5de2b0,
		64'hdb92371d2126e970, 64'h0324977504e8c90e
	};

	// rotation amounts for round key generation
	localparam int unsigned ROT_AMT [5] = '{19, 31, 67, 97, 109};

	function automatic byte_t gf_mul(input byte_t a, input byte_t b);
		logic [8:0] x;
		byte_t p;
		x = {1'b0, a};
		p = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p = p ^ x[7:0];
			x = {x[7:0], 1'b0};
			if (x[8]) x = x ^ 9'h11b;
		end
		return p;
	endfunction

	function automatic byte_t gf_inv(input byte_t a);
		byte_t r;
		byte_t bs;
		r = 8'd1;
		bs = a;
		for (int i = 0; i < 8; i++) begin
			if (i != 0) r = gf_mul(r, bs);
			bs = gf_mul(bs, bs);
		end
		return r;
	endfunction

	function automatic byte_t rotl8(input byte_t v, input int unsigned n);
		return byte_t'((v << n) | (v >> (8 - n)));
	endfunction

	function automatic byte_t sb1_f(input byte_t x);
		byte_t v;
		v = gf_inv(x);
		return v ^ rotl8(v, 1) ^ rotl8(v, 2) ^ rotl8(v, 3) ^ rotl8(v, 4) ^ 8'h63;
	endfunction

	localparam byte_t S2_LIN [8] = '{8'hAC, 8'hFD, 8'hC6, 8'h83, 8'h26, 8'hA7, 8'hFB, 8'h5F};

	function automatic byte_t sb2_f(input byte_t x);
		byte_t v;
		byte_t s;
		v = gf_inv(x);
		s = 8'hE2;
		for (int i = 0; i < 8; i++) if (v[i]) s = s ^ S2_LIN[i];
		return s;
	endfunction

	typedef byte_t sbox_t [256];

	function automatic sbox_t mk_sb1();
		sbox_t t;
		for (int i = 0; i < 256; i++) t[i] = sb1_f(byte_t'(i));
		return t;
	endfunction

	function automatic sbox_t mk_sb2();
		sbox_t t;
		for (int i = 0; i < 256; i++) t[i] = sb2_f(byte_t'(i));
		return t;
	endfunction

	function automatic sbox_t mk_ib1();
		sbox_t t;
		for (int i = 0; i < 256; i++) t[sb1_f(byte_t'(i))] = byte_t'(i);
		return t;
	endfunction

	function automatic sbox_t mk_ib2();
		sbox_t t;
		for (int i = 0; i < 256; i++) t[sb2_f(byte_t'(i))] = byte_t'(i);
		return t;
	endfunction

	localparam sbox_t SB1 = mk_sb1();
	localparam sbox_t SB2 = mk_sb2();
	localparam sbox_t IB1 = mk_ib1();
	localparam sbox_t IB2 = mk_ib2();

	// substitution layer; even = 0 uses S1,S2,S1inv,S2inv
	function automatic blk_t subst(input blk_t d, input logic even);
		blk_t o;
		for (int i = 0; i < 16; i++) begin
			byte_t b;
			b = d[BLK_W-1-8*i -: 8];
			case ({even, 2'(i % 4)})
				3'b000, 3'b110: b = SB1[b];
				3'b001, 3'b111: b = SB2[b];
				3'b010, 3'b100: b = IB1[b];
				default:        b = IB2[b];
			endcase
			o[BLK_W-1-8*i -: 8] = b;
		end
		return o;
	endfunction

	function automatic blk_t diffuse(input blk_t d);
		byte_t x [16];
		byte_t y [16];
		byte_t t;
		blk_t o;
		for (int i = 0; i < 16; i++) x[i] = d[BLK_W-1-8*i -: 8];
		t = x[3] ^ x[4] ^ x[9] ^ x[14];
		y[0] = x[6] ^ x[8] ^ x[13] ^ t;  y[5] = x[1] ^ x[10] ^ x[15] ^ t;
		y[11] = x[2] ^ x[7] ^ x[12] ^ t; y[14] = x[0] ^ x[5] ^ x[11] ^ t;
		t = x[2] ^ x[5] ^ x[8] ^ x[15];
		y[1] = x[7] ^ x[9] ^ x[12] ^ t;  y[4] = x[0] ^ x[11] ^ x[14] ^ t;
		y[10] = x[3] ^ x[6] ^ x[13] ^ t; y[15] = x[1] ^ x[4] ^ x[10] ^ t;
		t = x[1] ^ x[6] ^ x[11] ^ x[12];
		y[2] = x[4] ^ x[10] ^ x[15] ^ t; y[7] = x[3] ^ x[8] ^ x[13] ^ t;
		y[9] = x[0] ^ x[5] ^ x[14] ^ t;  y[12] = x[2] ^ x[7] ^ x[9] ^ t;
		t = x[0] ^ x[7] ^ x[10] ^ x[13];
		y[3] = x[5] ^ x[11] ^ x[14] ^ t; y[6] = x[2] ^ x[9] ^ x[12] ^ t;
		y[8] = x[1] ^ x[4] ^ x[15] ^ t;  y[13] = x[3] ^ x[6] ^ x[8] ^ t;
		for (int i = 0; i < 16; i++) o[BLK_W-1-8*i -: 8] = y[i];
		return o;
	endfunction

endpackage

// ----- hw/rtl/aria_ram.sv -----
// ----------------------------------------------------------------------------
// ARIA generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module aria_ram #(
	parameter int unsigned WIDTH = 128,
	parameter int unsigned DEPTH = 17
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/aria_block_encrypt_top.sv -----
// ----------------------------------------------------------------------------
// ARIA block encrypt top
// ARIA encryption with a key schedule kept in a round key RAM.
// ----------------------------------------------------------------------------
// One shared round unit runs one round a cycle reading one key a cycle; the
//   input is not ready while busy.
// Key schedule: 3 rounds on the shared unit, then 17 round-key writes after
//   reset and after every key write; no block is taken meanwhile.
// Reset: arst_n clears control state and the key registers, then expands the key.
module aria_block_encrypt_top #(
	parameter int unsigned KEY_BITS    = 128,
	parameter int unsigned ROUND_COUNT = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] plain_hi,
	input  logic [63:0] plain_lo,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] cipher_hi,
	output logic [63:0] cipher_lo
);

	localparam int unsigned NRND = (ROUND_COUNT < 2) ? 2 : ((ROUND_COUNT > 16) ? 16 : ROUND_COUNT);
	localparam int unsigned FIRST = (KEY_BITS > 192) ? 2 : ((KEY_BITS > 128) ? 1 : 0);
	localparam int unsigned NKEY = 17;
	localparam int unsigned KA_W = 5;

	localparam logic [2:0] ST_KS0  = 3'd0;
	localparam logic [2:0] ST_KS1  = 3'd1;
	localparam logic [2:0] ST_KS2  = 3'd2;
	localparam logic [2:0] ST_KGEN = 3'd3;
	localparam logic [2:0] ST_IDLE = 3'd4;
	localparam logic [2:0] ST_LOAD = 3'd5;
	localparam logic [2:0] ST_RND  = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	logic [2:0] state_q;
	logic [KA_W-1:0] cnt_q;
	logic [63:0] key_q [4];
	aria_pkg::blk_t w_q [4];
	aria_pkg::blk_t dat_q;
	aria_pkg::blk_t res_q;
	logic out_valid_q;

	// round key RAM
	logic ram_we;
	logic [KA_W-1:0] ram_waddr, ram_raddr;
	aria_pkg::blk_t ram_wdata, ram_rdata;

	aria_ram #(.WIDTH(aria_pkg::BLK_W), .DEPTH(NKEY)) u_rk (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	// shared round unit: key add, substitution, diffusion
	aria_pkg::blk_t ru_in, ru_key, ru_sub, ru_out;
	logic ru_even;
	assign ru_sub = aria_pkg::subst(ru_in ^ ru_key, ru_even);
	assign ru_out = aria_pkg::diffuse(ru_sub);

	// CK selection for the three schedule rounds
	function automatic aria_pkg::blk_t ck_sel(input int unsigned n);
		int unsigned k;
		k = (FIRST + n) % 3;
		return {aria_pkg::CK_WORDS[2*k], aria_pkg::CK_WORDS[2*k+1]};
	endfunction

	function automatic aria_pkg::blk_t rotr(input aria_pkg::blk_t v, input int unsigned n);
		return (v >> n) | (v << (aria_pkg::BLK_W - n));
	endfunction

	aria_pkg::blk_t kr;
	assign kr = {(KEY_BITS > 128) ? key_q[2] : 64'd0, (KEY_BITS > 192) ? key_q[3] : 64'd0};

	// round key generation from W0..W3
	aria_pkg::blk_t gen_key;
	always_comb begin
		aria_pkg::blk_t y;
		y = w_q[(cnt_q[1:0] + 2'd1)];
		case (cnt_q[4:2])
			3'd0:    y = rotr(y, aria_pkg::ROT_AMT[0]);
			3'd1:    y = rotr(y, aria_pkg::ROT_AMT[1]);
			3'd2:    y = rotr(y, aria_pkg::ROT_AMT[2]);
			3'd3:    y = rotr(y, aria_pkg::ROT_AMT[3]);
			default: y = rotr(y, aria_pkg::ROT_AMT[4]);
		endcase
		gen_key = w_q[cnt_q[1:0]] ^ y;
	end

	// round unit input mux
	always_comb begin
		ru_in = dat_q;
		ru_key = ram_rdata;
		ru_even = cnt_q[0];
		unique case (state_q)
			ST_KS0: begin
				ru_in = {key_q[0], key_q[1]};
				ru_key = ck_sel(0);
				ru_even = 1'b0;
			end
			ST_KS1: begin
				ru_in = w_q[1];
				ru_key = ck_sel(1);
				ru_even = 1'b1;
			end
			ST_KS2: begin
				ru_in = w_q[2];
				ru_key = ck_sel(2);
				ru_even = 1'b0;
			end
			// final layer always uses the even substitution
			ST_OUT: ru_even = 1'b1;
			default: ;
		endcase
	end

	assign ram_we = (state_q == ST_KGEN);
	assign ram_waddr = cnt_q;
	assign ram_wdata = gen_key;
	assign ram_raddr = (state_q == ST_IDLE) ? '0 : KA_W'(cnt_q + 5'd1);

	assign cfg_ready = (state_q == ST_IDLE) && !out_valid_q;
	assign in_ready = (state_q == ST_IDLE) && !out_valid_q && !cfg_valid;
	assign out_valid = out_valid_q;
	assign cipher_hi = res_q[127:64];
	assign cipher_lo = res_q[63:0];

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
		end else if (cfg_valid && cfg_ready) begin
			key_q[cfg_index] <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_KS0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_KS0: state_q <= ST_KS1;
				ST_KS1: state_q <= ST_KS2;
				ST_KS2: begin
					state_q <= ST_KGEN;
					cnt_q <= '0;
				end
				ST_KGEN: begin
					if (cnt_q == KA_W'(NKEY - 1)) state_q <= ST_IDLE;
					else cnt_q <= cnt_q + 5'd1;
				end
				ST_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						state_q <= ST_KS0;
					end else if (in_valid && in_ready) begin
						state_q <= ST_RND;
						cnt_q <= '0;
					end
				end
				ST_LOAD: state_q <= ST_RND;
				ST_RND: begin
					if (cnt_q == KA_W'(NRND - 2)) state_q <= ST_OUT;
					cnt_q <= cnt_q + 5'd1;
				end
				ST_OUT: begin
					if (cnt_q == KA_W'(NRND)) begin
						state_q <= ST_IDLE;
						out_valid_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_KS0: begin
				w_q[0] <= {key_q[0], key_q[1]};
				w_q[1] <= ru_out ^ kr;
			end
			ST_KS1: w_q[2] <= ru_out ^ w_q[0];
			ST_KS2: w_q[3] <= ru_out ^ w_q[1];
			ST_IDLE: if (in_valid && in_ready) dat_q <= {plain_hi, plain_lo};
			ST_RND: dat_q <= ru_out;
			ST_OUT: begin
				if (cnt_q == KA_W'(NRND - 1))
					dat_q <= ru_sub;
				else
					res_q <= dat_q ^ ram_rdata;
			end
			default: ;
		endcase
	end

endmodule

// ----- hw/rtl/aria_chk.sv -----
// ----------------------------------------------------------------------------
// ARIA port checker
// Checks handshake rules seen at the top level ports.
// ----------------------------------------------------------------------------
module aria_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        cfg_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] cipher_hi
);

	// result holds while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cipher_hi))
		else $error("result changed while stalled");

	// no new beat while a result waits
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while result pending");

	// accepted beat blocks the input next cycle
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready && !cfg_ready)
		else $error("ready right after accept");

	// no result right after accept
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid)
		else $error("result too early");

endmodule

bind aria_block_encrypt_top aria_chk u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.cfg_ready(cfg_ready), .out_valid(out_valid), .out_ready(out_ready),
	.cipher_hi(cipher_hi)
);

// ----- tb/tb_aria_block_encrypt_top.sv -----
// ----------------------------------------------------------------------------
// ARIA block encrypt testbench
// Drives plaintext blocks and key writes through valid/ready channels and
// checks each ciphertext beat against an in-bench ARIA-128 model (key
// schedule plus encryption), with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_aria_block_encrypt_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned KEY_BITS = 128;
	localparam int unsigned ROUND_COUNT = 12;
	localparam int unsigned STALL_LIMIT = 5000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned RAND_ITEMS = 450;

	// key register indexes
	typedef enum logic [1:0] {KEY_W0 = 2'd0, KEY_W1 = 2'd1, KEY_W2 = 2'd2, KEY_W3 = 2'd3} key_idx_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = KEY_W0;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [63:0] plain_hi = '0;
	logic [63:0] plain_lo = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] cipher_hi;
	logic [63:0] cipher_lo;

	aria_block_encrypt_top #(.KEY_BITS(KEY_BITS), .ROUND_COUNT(ROUND_COUNT)) DUT (.*);

	always #6 clk = ~clk;

	// ---------------- cipher model ----------------
	typedef struct {
		logic [127:0] ct;
		logic         typed;
		logic [127:0] typed_ct;
	} cipher_exp_t;

	logic [7:0]   s1_tab [256], s2_tab [256], s1_inv [256], s2_inv [256];
	logic [63:0]  key_reg [4];
	logic [127:0] round_key [17];
	cipher_exp_t  cipher_q [$];

	function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
		logic [8:0] acc;
		logic [7:0] p;
		acc = {1'b0, a};
		p = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p ^= acc[7:0];
			acc = {acc[7:0], 1'b0};
			if (acc[8]) acc ^= 9'h11b;
		end
		return p;
	endfunction

	function automatic logic [7:0] rol8(logic [7:0] v, int n);
		return (v << n) | (v >> (8 - n));
	endfunction

	task automatic build_sboxes();
		logic [7:0] inv, a1, a2;
		logic [7:0] lin [8];
		lin = '{8'hAC, 8'hFD, 8'hC6, 8'h83, 8'h26, 8'hA7, 8'hFB, 8'h5F};
		for (int x = 0; x < 256; x++) begin
			// inverse as x^254
			inv = 8'd1;
			for (int k = 0; k < 254; k++) inv = gmul(inv, 8'(x));
			a1 = inv ^ rol8(inv, 1) ^ rol8(inv, 2) ^ rol8(inv, 3) ^ rol8(inv, 4) ^ 8'h63;
			a2 = 8'hE2;
			for (int k = 0; k < 8; k++) if (inv[k]) a2 ^= lin[k];
			s1_tab[x] = a1; s1_inv[a1] = 8'(x);
			s2_tab[x] = a2; s2_inv[a2] = 8'(x);
		end
	endtask

	// substitution layer; even layer starts with the inverse boxes
	function automatic logic [127:0] sub_layer(logic [127:0] d, bit even);
		logic [7:0] b;
		for (int i = 0; i < 16; i++) begin
			b = d[127-8*i -: 8];
			case ((i % 4) ^ (even ? 2 : 0))
				0: b = s1_tab[b];
				1: b = s2_tab[b];
				2: b = s1_inv[b];
				default: b = s2_inv[b];
			endcase
			d[127-8*i -: 8] = b;
		end
		return d;
	endfunction

	function automatic logic [127:0] mix_layer(logic [127:0] d);
		logic [7:0] x [16];
		logic [7:0] y [16];
		logic [7:0] t;
		logic [127:0] o;
		for (int i = 0; i < 16; i++) x[i] = d[127-8*i -: 8];
		t = x[3] ^ x[4] ^ x[9] ^ x[14];
		y[0] = x[6] ^ x[8] ^ x[13] ^ t;  y[5] = x[1] ^ x[10] ^ x[15] ^ t;
		y[11] = x[2] ^ x[7] ^ x[12] ^ t; y[14] = x[0] ^ x[5] ^ x[11] ^ t;
		t = x[2] ^ x[5] ^ x[8] ^ x[15];
		y[1] = x[7] ^ x[9] ^ x[12] ^ t;  y[4] = x[0] ^ x[11] ^ x[14] ^ t;
		y[10] = x[3] ^ x[6] ^ x[13] ^ t; y[15] = x[1] ^ x[4] ^ x[10] ^ t;
		t = x[1] ^ x[6] ^ x[11] ^ x[12];
		y[2] = x[4] ^ x[10] ^ x[15] ^ t; y[7] = x[3] ^ x[8] ^ x[13] ^ t;
		y[9] = x[0] ^ x[5] ^ x[14] ^ t;  y[12] = x[2] ^ x[7] ^ x[9] ^ t;
		t = x[0] ^ x[7] ^ x[10] ^ x[13];
		y[3] = x[5] ^ x[11] ^ x[14] ^ t; y[6] = x[2] ^ x[9] ^ x[12] ^ t;
		y[8] = x[1] ^ x[4] ^ x[15] ^ t;  y[13] = x[3] ^ x[6] ^ x[8] ^ t;
		for (int i = 0; i < 16; i++) o[127-8*i -: 8] = y[i];
		return o;
	endfunction

	function automatic logic [127:0] aria_round(logic [127:0] d, logic [127:0] k, bit even);
		return mix_layer(sub_layer(d ^ k, even));
	endfunction

	function automatic logic [127:0] rotr(logic [127:0] v, int n);
		return (v >> n) | (v << (128 - n));
	endfunction

	task automatic expand_round_keys();
		logic [127:0] ck [3];
		logic [127:0] w [4];
		logic [127:0] kr;
		int rot [5];
		int c;
		ck = '{128'h517cc1b727220a94fe13abe8fa9a6ee0, 128'h6db14acc9e21c820ff28b1d5ef5de2b0,
			128'hdb92371d2126e9700324977504e8c90e};
		rot = '{19, 31, 67, 97, 109};
		c = (KEY_BITS > 192) ? 2 : ((KEY_BITS > 128) ? 1 : 0);
		kr = {(KEY_BITS > 128) ? key_reg[2] : 64'd0, (KEY_BITS > 192) ? key_reg[3] : 64'd0};
		w[0] = {key_reg[0], key_reg[1]};
		w[1] = aria_round(w[0], ck[c], 1'b0) ^ kr;
		w[2] = aria_round(w[1], ck[(c + 1) % 3], 1'b1) ^ w[0];
		w[3] = aria_round(w[2], ck[(c + 2) % 3], 1'b0) ^ w[1];
		for (int i = 0; i < 17; i++)
			round_key[i] = w[i % 4] ^ rotr(w[(i + 1) % 4], rot[i / 4]);
	endtask

	function automatic logic [127:0] aria_encrypt(logic [127:0] pt);
		int n;
		n = ROUND_COUNT;
		if (n < 2) n = 2;
		if (n > 16) n = 16;
		for (int r = 0; r < n - 1; r++) pt = aria_round(pt, round_key[r], r[0]);
		return sub_layer(pt ^ round_key[n-1], 1'b1) ^ round_key[n];
	endfunction

	// ---------------- monitor and checker ----------------
	int          fail_cnt = 0;
	int unsigned quiet_cycles = 0;
	bit          next_typed = 1'b0;
	logic [127:0] next_typed_ct = '0;

	initial begin
		build_sboxes();
		for (int i = 0; i < 4; i++) key_reg[i] = '0;
		expand_round_keys();
	end

	always @(posedge clk) begin
		cipher_exp_t e;
		bit beat;
		beat = 1'b0;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				key_reg[cfg_index] = cfg_data;
				expand_round_keys();
				beat = 1'b1;
			end
			if (in_valid && in_ready) begin
				e.ct = aria_encrypt({plain_hi, plain_lo});
				e.typed = next_typed;
				e.typed_ct = next_typed_ct;
				cipher_q.push_back(e);
				beat = 1'b1;
			end
			if (out_valid && out_ready) begin
				beat = 1'b1;
				if (cipher_q.size() == 0) begin
					$display("%0t: unexpected cipher beat %h_%h", $time, cipher_hi, cipher_lo);
					fail_cnt++;
				end else begin
					e = cipher_q.pop_front();
					if (cipher_hi !== e.ct[127:64]) begin
						$display("%0t: cipher_hi exp %h got %h", $time, e.ct[127:64], cipher_hi);
						fail_cnt++;
					end
					if (cipher_lo !== e.ct[63:0]) begin
						$display("%0t: cipher_lo exp %h got %h", $time, e.ct[63:0], cipher_lo);
						fail_cnt++;
					end
					if (e.typed && {cipher_hi, cipher_lo} !== e.typed_ct) begin
						$display("%0t: known vector exp %h got %h_%h", $time, e.typed_ct,
							cipher_hi, cipher_lo);
						fail_cnt++;
					end
				end
			end
			quiet_cycles <= beat ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// ---------------- result side ----------------
	int unsigned tx_idle_pct = 16;
	int unsigned rx_idle_pct = 88;
	bit          hold_req = 1'b0;

	always begin
		@(posedge clk);
		if (hold_req) begin
			out_ready <= 1'b0;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_req = 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// ---------------- stimulus ----------------
	typedef struct packed {
		logic [63:0]  hi;
		logic [63:0]  lo;
		logic         known;
		logic [127:0] ct;
	} vec_row_t;

	// rows 0..6 run with the reset (all-zero) key, the rest with the standard test key
	localparam int KEY_SWITCH_ROW = 7;
	localparam vec_row_t VEC_ROWS [0:10] = '{
		'{64'h0, 64'h0, 1'b0, 128'h0},
		'{64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0, 128'h0},
		'{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, 128'h0},
		'{64'h8000000000000000, 64'h0000000000000001, 1'b0, 128'h0},
		'{64'h0, 64'hffffffffffffffff, 1'b0, 128'h0},
		'{64'hffffffffffffffff, 64'h0, 1'b0, 128'h0},
		'{64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 128'h0},
		'{64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
			128'hd718fbd6ab644c739da95f3be6451778},
		'{64'h0, 64'h0, 1'b0, 128'h0},
		'{64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0, 128'h0},
		'{64'h00000000000000ff, 64'hff00000000000000, 1'b0, 128'h0}
	};

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// one plaintext beat, then an optional gap
	task automatic send_block(logic [63:0] hi, logic [63:0] lo);
		in_valid <= 1'b1;
		plain_hi <= hi;
		plain_lo <= lo;
		do @(posedge clk); while (!in_ready);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// let the monitor log the last accepted beat before the queue is checked
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (cipher_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_key(key_idx_e idx, logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_key(logic [63:0] k0, k1, k2, k3);
		drain();
		write_key(KEY_W0, k0);
		write_key(KEY_W1, k1);
		write_key(KEY_W2, k2);
		write_key(KEY_W3, k3);
	endtask

	task automatic random_blocks(int cnt);
		logic [63:0] h, l;
		for (int i = 0; i < cnt; i++) begin
			h = rand64();
			l = rand64();
			case ($urandom_range(9))
				0: h = '0;
				1: l = '1;
				default: ;
			endcase
			send_block(h, l);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (VEC_ROWS[i]) begin
			if (i == KEY_SWITCH_ROW)
				// upper words are ignored by a 128-bit key
				load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f, rand64(), rand64());
			next_typed <= VEC_ROWS[i].known;
			next_typed_ct <= VEC_ROWS[i].ct;
			send_block(VEC_ROWS[i].hi, VEC_ROWS[i].lo);
		end
		next_typed <= 1'b0;

		// sender idles lightly, receiver heavily; long receiver hold-off
		load_key('1, '1, '1, '1);
		hold_req = 1'b1;
		random_blocks(RAND_ITEMS / 3);

		// swap the idling sides; pause until all results are back midway
		load_key(rand64(), rand64(), rand64(), rand64());
		tx_idle_pct = 88;
		rx_idle_pct = 16;
		random_blocks(RAND_ITEMS / 6);
		drain();
		random_blocks(RAND_ITEMS / 6);

		// no idling either side
		load_key(rand64(), 64'h0, '1, rand64());
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		random_blocks(RAND_ITEMS / 3);

		drain();
		if (fail_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
